@@ design/aip_pkg.sv @@
`timescale 1ns / 1ps

package aip_pkg;

  localparam int unsigned CountWidthDef = 16;
  localparam int unsigned OutCountW     = 16;
  localparam int unsigned ValueW        = 64;

  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChVt     = 8'h0B;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChZero   = 8'd48;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUcA    = 8'h41;
  localparam logic [7:0] ChUcF    = 8'h46;
  localparam logic [7:0] ChLcA    = 8'h61;
  localparam logic [7:0] ChLcF    = 8'h66;
  localparam logic [7:0] ChLcX    = 8'h78;
  localparam logic [7:0] UcOffset = 8'd55;
  localparam logic [7:0] LcOffset = 8'd87;

  typedef enum logic [1:0] {
    BASE_AUTO = 2'd0,
    BASE_OCT  = 2'd1,
    BASE_DEC  = 2'd2,
    BASE_HEX  = 2'd3
  } base_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WS     = 3'd1,
    PH_PLUS   = 3'd2,
    PH_SIGN   = 3'd3,
    PH_ZERO   = 3'd4,
    PH_DIGITS = 3'd5,
    PH_DONE   = 3'd6
  } phase_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic [1:0] base_select;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueW-1:0]    value;
    logic        [OutCountW-1:0] chars_consumed;
    logic                        digit_seen;
  } out_item_t;

  // parser state apart from the character count
  typedef struct packed {
    phase_e            phase;
    logic [ValueW-1:0] acc;
    logic              neg;
    base_e             base;
    logic              any;
  } pst_t;

  localparam pst_t PstReset = '{
    phase: PH_IDLE, acc: '0, neg: 1'b0, base: BASE_AUTO, any: 1'b0
  };

endpackage

@@ design/aip_step.sv @@
`timescale 1ns / 1ps

module aip_step #(
  parameter int unsigned COUNT_WIDTH = aip_pkg::CountWidthDef
) (
  input  aip_pkg::pst_t      st_i,
  input  logic [COUNT_WIDTH-1:0] cnt_i,
  input  aip_pkg::in_item_t  item_i,
  output aip_pkg::pst_t      st_o,
  output logic [COUNT_WIDTH-1:0] cnt_o,
  output logic               emit_o,
  output aip_pkg::out_item_t res_o
);

  import aip_pkg::*;

  pst_t                   w;
  pst_t                   nxt;
  logic [COUNT_WIDTH-1:0] cw;
  logic [COUNT_WIDTH-1:0] cn;
  logic                   ok;
  logic                   num;
  logic                   dig;
  logic                   dok;
  base_e                  eb;
  logic [7:0]             c;
  logic                   is_dec;
  logic                   is_uc;
  logic                   is_lc;
  logic                   is_space;
  logic [3:0]             dv;
  logic [ValueW-1:0]      scaled;
  logic [OutCountW-1:0]   cnt_sat;

  assign c      = item_i.char_code;
  assign is_dec = (c >= ChZero) && (c <= ChNine);
  assign is_uc  = (c >= ChUcA) && (c <= ChUcF);
  assign is_lc  = (c >= ChLcA) && (c <= ChLcF);
  assign is_space = (c == ChSpace) || (c == ChLf) || (c == ChTab) ||
                    (c == ChCr) || (c == ChVt) || (c == ChFf);

  always_comb begin
    if (is_dec) begin
      dv = 4'(c - ChZero);
    end else if (is_uc) begin
      dv = 4'(c - UcOffset);
    end else begin
      dv = 4'(c - LcOffset);
    end
  end

  always_comb begin
    w  = st_i;
    cw = cnt_i;
    if (st_i.phase == PH_IDLE) begin
      w = '{phase: PH_WS, acc: '0, neg: 1'b0,
            base: base_e'(item_i.base_select), any: 1'b0};
      cw = '0;
    end

    nxt    = w;
    ok     = 1'b0;
    num    = 1'b0;
    dig    = 1'b0;
    dok    = 1'b0;
    scaled = '0;
    eb     = w.base;

    unique case (w.phase)
      PH_WS: begin
        if (is_space) begin
          ok = 1'b1;
        end else if (c == ChPlus) begin
          ok        = 1'b1;
          nxt.phase = PH_PLUS;
        end else if (c == ChMinus) begin
          ok        = 1'b1;
          nxt.neg   = 1'b1;
          nxt.phase = PH_SIGN;
        end else begin
          num = 1'b1;
        end
      end
      PH_PLUS: begin
        if (c == ChMinus) begin
          ok        = 1'b1;
          nxt.neg   = 1'b1;
          nxt.phase = PH_SIGN;
        end else begin
          num = 1'b1;
        end
      end
      PH_SIGN: num = 1'b1;
      PH_ZERO: begin
        if (c == ChLcX) begin
          ok        = 1'b1;
          nxt.base  = BASE_HEX;
          nxt.phase = PH_DIGITS;
        end else begin
          dig = 1'b1;
          eb  = (w.base == BASE_AUTO) ? BASE_OCT : w.base;
        end
      end
      default: dig = 1'b1;
    endcase

    if (num) begin
      if ((c == ChZero) && ((w.base == BASE_AUTO) || (w.base == BASE_HEX))) begin
        ok        = 1'b1;
        nxt.any   = 1'b1;
        nxt.phase = PH_ZERO;
      end else begin
        dig = 1'b1;
        eb  = (w.base == BASE_AUTO) ? BASE_DEC : w.base;
      end
    end

    if (dig) begin
      nxt.base = eb;
      unique case (eb)
        BASE_OCT: begin
          dok    = is_dec && (dv < 4'd8);
          scaled = {w.acc[ValueW-4:0], 3'b000};
        end
        BASE_DEC: begin
          dok    = is_dec;
          scaled = {w.acc[ValueW-4:0], 3'b000} + {w.acc[ValueW-2:0], 1'b0};
        end
        BASE_HEX: begin
          dok    = is_dec || is_uc || is_lc;
          scaled = {w.acc[ValueW-5:0], 4'b0000};
        end
        default: dok = 1'b0;
      endcase
      if (dok) begin
        ok        = 1'b1;
        nxt.acc   = scaled + ValueW'(dv);
        nxt.any   = 1'b1;
        nxt.phase = PH_DIGITS;
      end
    end

    cn = (ok && (cw != '1)) ? cw + 1'b1 : cw;
  end

  generate
    if (COUNT_WIDTH > OutCountW) begin : g_sat
      assign cnt_sat = (|cn[COUNT_WIDTH-1:OutCountW]) ? '1 : cn[OutCountW-1:0];
    end else begin : g_ext
      assign cnt_sat = OutCountW'(cn);
    end
  endgenerate

  always_comb begin
    res_o.value          = nxt.neg ? (ValueW'(0) - nxt.acc) : nxt.acc;
    res_o.chars_consumed = cnt_sat;
    res_o.digit_seen     = nxt.any;
    if (st_i.phase == PH_DONE) begin
      emit_o = 1'b0;
      st_o   = item_i.last ? PstReset : st_i;
      cnt_o  = item_i.last ? '0 : cnt_i;
    end else begin
      emit_o = !ok || item_i.last;
      if (!emit_o) begin
        st_o  = nxt;
        cnt_o = cn;
      end else if (item_i.last) begin
        st_o  = PstReset;
        cnt_o = '0;
      end else begin
        st_o       = nxt;
        st_o.phase = PH_DONE;
        cnt_o      = cn;
      end
    end
  end

endmodule

@@ design/aip_out_reg.sv @@
`timescale 1ns / 1ps

module aip_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  aip_pkg::out_item_t data_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output aip_pkg::out_item_t out_data_o
);

  import aip_pkg::*;

  logic      valid_q;
  out_item_t data_q;

  assign ready_o     = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule

@@ design/ascii_integer_parser.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        sink       in_valid_i / in_stall_o   in_data_i  (char, base, last)
// out       source     out_valid_o / out_stall_i out_data_o (value, count, digit)
//
// One character per cycle sustained while the output is not stalled; a result passes
// through the input register and then the result register after its character is accepted.
// Reset clears the parser to idle and empties both registers.
// A stalled output holds the input register only when that character yields a result.

module ascii_integer_parser #(
  parameter int unsigned COUNT_WIDTH = aip_pkg::CountWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  aip_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output aip_pkg::out_item_t out_data_o
);

  import aip_pkg::*;

  logic                   in_valid_q;
  in_item_t               in_q;
  pst_t                   st_q;
  pst_t                   st_d;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic [COUNT_WIDTH-1:0] cnt_d;
  logic                   emit;
  out_item_t              res;
  logic                   out_ready;
  logic                   advance;

  aip_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .st_i  (st_q),
    .cnt_i (cnt_q),
    .item_i(in_q),
    .st_o  (st_d),
    .cnt_o (cnt_d),
    .emit_o(emit),
    .res_o (res)
  );

  aip_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && emit),
    .data_i     (res),
    .ready_o    (out_ready),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  assign advance    = in_valid_q && (!emit || out_ready);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      st_q       <= PstReset;
      cnt_q      <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        st_q  <= st_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit |=> out_valid_o)
    else $error("result transaction not registered");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.last |=> (st_q.phase == PH_IDLE) && (cnt_q == '0))
    else $error("parser not idle after final character");

  a_acc_needs_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.any |-> (st_q.acc == '0))
    else $error("accumulator set without a digit");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && emit && out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

endmodule

@@ dv/ascii_integer_parser_tb.sv @@
`timescale 1ns / 1ps

module ascii_integer_parser_tb;
  import aip_pkg::*;

  localparam int unsigned CountW     = CountWidthDef;
  localparam logic [31:0] CountMax   = 32'((64'd1 << CountW) - 1);
  localparam int          CycleLimit = 600000;
  localparam int          RandItems  = 1000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  ascii_integer_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // parser state as tracked by the testbench
  phase_e      ph;
  logic [63:0] acc;
  logic [31:0] cnt;
  logic        neg;
  base_e       radix_sel;
  logic        seen_digit;

  out_item_t   parsed_q[$];
  out_item_t   want;
  int          fails;
  int          live_items;
  int          cycles;
  int          rx_wait;
  bit          tx_idle_on;
  bit          rx_idle_on;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic clear_state();
    ph         = PH_IDLE;
    acc        = '0;
    cnt        = '0;
    neg        = 1'b0;
    radix_sel  = BASE_AUTO;
    seen_digit = 1'b0;
  endtask

  function automatic bit is_blank(logic [7:0] c);
    return c == ChSpace || c == ChLf || c == ChTab || c == ChCr || c == ChVt || c == ChFf;
  endfunction

  function automatic int digit_of(logic [7:0] c, base_e b);
    int d;
    d = -1;
    if (c >= ChZero && c <= ChNine) d = int'(c) - int'(ChZero);
    else if (c >= ChUcA && c <= ChUcF) d = int'(c) - int'(UcOffset);
    else if (c >= ChLcA && c <= ChLcF) d = int'(c) - int'(LcOffset);
    if (b == BASE_AUTO) d = -1;
    if (b == BASE_OCT && d > 7) d = -1;
    if (b == BASE_DEC && d > 9) d = -1;
    return d;
  endfunction

  function automatic bit take_digit(logic [7:0] c);
    int d;
    logic [63:0] r;
    d = digit_of(c, radix_sel);
    if (d < 0) return 1'b0;
    r = (radix_sel == BASE_OCT) ? 64'd8 : (radix_sel == BASE_DEC) ? 64'd10 : 64'd16;
    acc        = acc * r + 64'(d);
    seen_digit = 1'b1;
    ph         = PH_DIGITS;
    return 1'b1;
  endfunction

  function automatic bit start_number(logic [7:0] c);
    if (c == ChZero && (radix_sel == BASE_AUTO || radix_sel == BASE_HEX)) begin
      seen_digit = 1'b1;
      ph         = PH_ZERO;
      return 1'b1;
    end
    if (radix_sel == BASE_AUTO) radix_sel = BASE_DEC;
    return take_digit(c);
  endfunction

  function automatic bit take_char(logic [7:0] c);
    case (ph)
      PH_WS: begin
        if (is_blank(c)) return 1'b1;
        if (c == ChPlus) begin
          ph = PH_PLUS;
          return 1'b1;
        end
        if (c == ChMinus) begin
          neg = 1'b1;
          ph  = PH_SIGN;
          return 1'b1;
        end
        return start_number(c);
      end
      PH_PLUS: begin
        if (c == ChMinus) begin
          neg = 1'b1;
          ph  = PH_SIGN;
          return 1'b1;
        end
        return start_number(c);
      end
      PH_SIGN: return start_number(c);
      PH_ZERO: begin
        if (c == ChLcX) begin
          radix_sel = BASE_HEX;
          ph        = PH_DIGITS;
          return 1'b1;
        end
        if (radix_sel == BASE_AUTO) radix_sel = BASE_OCT;
        return take_digit(c);
      end
      default: return take_digit(c);
    endcase
  endfunction

  task automatic parse_char(in_item_t it);
    bit        ok;
    out_item_t res;
    if (ph == PH_DONE) begin
      if (it.last) clear_state();
      return;
    end
    if (ph == PH_IDLE || ph > PH_DONE) begin
      clear_state();
      radix_sel = base_e'(it.base_select);
      ph        = PH_WS;
    end
    ok = take_char(it.char_code);
    if (ok && cnt < CountMax) cnt++;
    if (ok && !it.last) return;
    res.value          = neg ? 64'd0 - acc : acc;
    res.chars_consumed = (cnt > 32'hFFFF) ? 16'hFFFF : cnt[15:0];
    res.digit_seen     = seen_digit;
    parsed_q.push_back(res);
    if (it.last) clear_state();
    else ph = PH_DONE;
  endtask

  task automatic send_char(logic [7:0] c, logic [1:0] b, logic lst);
    int       gap;
    in_item_t it;
    gap = tx_idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.char_code   = c;
    it.base_select = b;
    it.last        = lst;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    live_items++;
    parse_char(it);
  endtask

  // base is only meaningful on the first character; the rest get noise
  task automatic send_bytes(logic [7:0] txt[$], logic [1:0] b);
    for (int i = 0; i < txt.size(); i++) begin
      send_char(txt[i], (i == 0) ? b : 2'($urandom_range(0, 3)), i == txt.size() - 1);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (parsed_q.size() == 0) begin
          $error("unexpected result: value %0d", out_data_o.value);
          fails++;
        end else begin
          want = parsed_q.pop_front();
          if (out_data_o.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_data_o.value);
            fails++;
          end
          if (out_data_o.chars_consumed !== want.chars_consumed) begin
            $error("chars_consumed: expected %0d, got %0d", want.chars_consumed,
                   out_data_o.chars_consumed);
            fails++;
          end
          if (out_data_o.digit_seen !== want.digit_seen) begin
            $error("digit_seen: expected %0b, got %0b", want.digit_seen,
                   out_data_o.digit_seen);
            fails++;
          end
        end
        rx_wait = rx_idle_on ? $urandom_range(0, 5) : 0;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall_i <= (rx_wait != 0);
    end
  end

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 5))
      0: return ChSpace;
      1: return ChLf;
      2: return ChTab;
      3: return ChCr;
      4: return ChVt;
      default: return ChFf;
    endcase
  endfunction

  function automatic logic [7:0] rand_digit(base_e e);
    int d;
    d = $urandom_range(0, (e == BASE_OCT) ? 7 : (e == BASE_DEC) ? 9 : 15);
    if (d < 10) return 8'(ChZero + d);
    return 8'(($urandom_range(0, 1) ? UcOffset : LcOffset) + d);
  endfunction

  function automatic logic [7:0] rand_awkward();
    case ($urandom_range(0, 9))
      0: return ChSpace;
      1: return ChPlus;
      2: return ChMinus;
      3: return ChZero;
      4: return ChLcX;
      5: return "X";
      6: return ChNine;
      7: return "8";
      8: return ChLcF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_number();
    logic [7:0] txt[$];
    base_e      b;
    base_e      e;
    int         n;
    b = base_e'($urandom_range(0, 3));
    e = b;
    repeat ($urandom_range(0, 2)) txt.push_back(rand_blank());
    case ($urandom_range(0, 3))
      1: txt.push_back(ChPlus);
      2: txt.push_back(ChMinus);
      3: begin
        txt.push_back(ChPlus);
        txt.push_back(ChMinus);
      end
      default: ;
    endcase
    if (b == BASE_AUTO) begin
      case ($urandom_range(0, 2))
        0: begin
          txt.push_back(ChZero);
          txt.push_back(ChLcX);
          e = BASE_HEX;
        end
        1: begin
          txt.push_back(ChZero);
          e = BASE_OCT;
        end
        default: begin
          txt.push_back(8'(ChZero + $urandom_range(1, 9)));
          e = BASE_DEC;
        end
      endcase
    end else if (b == BASE_HEX && $urandom_range(0, 1)) begin
      txt.push_back(ChZero);
      txt.push_back(ChLcX);
    end
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 8);
    repeat (n) txt.push_back(rand_digit(e));
    if ($urandom_range(0, 4) < 2) begin
      repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(0, 255)));
    end
    send_bytes(txt, b);
  endtask

  task automatic send_junk(bit raw);
    logic [7:0] txt[$];
    repeat ($urandom_range(1, 6)) begin
      txt.push_back(raw ? 8'($urandom_range(0, 255)) : rand_awkward());
    end
    send_bytes(txt, 2'($urandom_range(0, 3)));
  endtask

  task automatic run_directed();
    logic [7:0] txt[$];
    txt = {ChFf, ChVt, ChPlus, ChMinus, "7"};
    send_bytes(txt, BASE_DEC);
    txt = {ChSpace, ChTab, ChLf, ChCr, ChZero, ChLcX, "1", ChUcF};
    send_bytes(txt, BASE_AUTO);
    // uppercase X is no prefix; rejected on the last character
    txt = {ChZero, "X"};
    send_bytes(txt, BASE_AUTO);
    txt = {ChMinus, ChPlus};
    send_bytes(txt, BASE_DEC);
    // result on z, trailing character ignored
    txt = {ChNine, "z", "1"};
    send_bytes(txt, BASE_DEC);
    txt = {ChZero, ChLcX};
    send_bytes(txt, BASE_HEX);
    txt = {8'hFF};
    send_bytes(txt, BASE_HEX);
    txt = {ChZero, "8"};
    send_bytes(txt, BASE_AUTO);
    txt = {ChUcF};
    send_bytes(txt, BASE_AUTO);
  endtask

  task automatic run_random();
    int goal;
    int pick;
    goal = live_items + RandItems;
    while (live_items < goal) begin
      if ($urandom_range(0, 31) == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) send_number();
      else send_junk(pick == 9);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    fails       = 0;
    live_items  = 0;
    rx_wait     = 0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    clear_state();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random();

    in_valid_i <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fails == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
